FILE: sv/kce_pkg.sv
package kce_pkg;

    // default depth of the item list
    localparam int MAX_ITEMS_DEF = 16;

    // fixed field widths
    localparam int ITEM_W = 32;
    localparam int SIZE_W = 5;
    localparam int OP_W   = 2;
    localparam int USER_W = 3;

    // operation codes on the input stream
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;

    // flag positions in the output tuser
    localparam int USER_EMPTY = 0;
    localparam int USER_EXH   = 1;
    localparam int USER_FULL  = 2;

endpackage

FILE: sv/kce_ram.sv
module kce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/k_combination_enumerator_top.sv
// Lexicographic k-combination generator. Items are loaded into a list of up to
// MAX_ITEMS signed 32-bit values by a clear transaction (tuser 0) followed by
// append transactions (tuser 1, value in tdata); a next transaction (tuser 2)
// emits the following k-element subset as a run of k output transactions, item
// value in tdata, tlast on the final one. The output tuser carries flags: an
// empty subset (k = 0, first request only), exhaustion (k beyond the item count
// or all subsets given) and a dropped append to a full list; each of those is a
// single transaction with tlast low except for the empty subset. k is written
// through cfg_we/cfg_wdata while the block is idle and resets to 1; a clear, an
// append or a write of k restarts the enumeration. Clear, append and unused
// codes are handled in the idle state. A next request walks the k positions,
// each by two dependent reads (position memory, then item memory, both with a
// registered read) and a load into the output register once that is free; then
// it rewrites the positions from the pivot to the end when stepping to the
// following subset. Positions and items live in two single-port-write
// synchronous memories; no clearing pass is needed after reset.
module k_combination_enumerator_top #(
    parameter int MAX_ITEMS = kce_pkg::MAX_ITEMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kce_pkg::ITEM_W-1:0]    s_tdata,   // item_value
    input  logic [kce_pkg::OP_W-1:0]      s_tuser,   // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kce_pkg::ITEM_W-1:0]    m_tdata,   // subset_item
    output logic                          m_tlast,   // last_of_subset
    output logic [kce_pkg::USER_W-1:0]    m_tuser,   // empty_subset, exhausted, list_full
    input  logic                          cfg_we,
    input  logic [kce_pkg::SIZE_W-1:0]    cfg_wdata  // k, items per subset
);

    localparam int IDXW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int SW   = kce_pkg::SIZE_W;
    localparam int CW   = ((CNTW > SW) ? CNTW : SW) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RPOS  = 3'd1;
    localparam logic [2:0] ST_RITEM = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_ADV   = 3'd4;

    logic [2:0]                  state_reg, state_next;
    logic [SW-1:0]               k_reg, k_next;
    logic [CNTW-1:0]             count_reg, count_next;
    logic                        started_reg, started_next;
    logic                        finished_reg, finished_next;
    logic [SW-1:0]               j_reg, j_next;
    logic                        piv_found_reg, piv_found_next;
    logic [SW-1:0]               piv_j_reg, piv_j_next;
    logic [IDXW-1:0]             piv_val_reg, piv_val_next;
    logic                        out_valid_reg, out_valid_next;
    logic [kce_pkg::ITEM_W-1:0]  out_data_reg, out_data_next;
    logic                        out_last_reg, out_last_next;
    logic [kce_pkg::USER_W-1:0]  out_user_reg, out_user_next;

    // memory ports
    logic                        item_we, item_re;
    logic [IDXW-1:0]             item_waddr, item_raddr;
    logic [kce_pkg::ITEM_W-1:0]  item_rdata;
    logic                        pos_we, pos_re;
    logic [IDXW-1:0]             pos_waddr, pos_wdata, pos_raddr, pos_rdata;

    logic                        s_fire, out_free, too_big, list_room, at_max, j_last;
    logic [IDXW-1:0]             pos_cur;
    logic [SW-1:0]               k_m1;

    kce_ram #(.WIDTH(kce_pkg::ITEM_W), .DEPTH(MAX_ITEMS)) u_item_ram (
        .clk   (clk),
        .we    (item_we),
        .waddr (item_waddr),
        .wdata (s_tdata),
        .re    (item_re),
        .raddr (item_raddr),
        .rdata (item_rdata)
    );

    kce_ram #(.WIDTH(IDXW), .DEPTH(MAX_ITEMS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    // handshake and shared decodes
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign too_big   = CW'(k_reg) > CW'(count_reg);
    assign list_room = count_reg != CNTW'(MAX_ITEMS);
    assign k_m1      = k_reg - SW'(1);
    assign j_last    = j_reg == k_m1;
    // first request after a restart uses positions 0..k-1
    assign pos_cur   = started_reg ? pos_rdata : IDXW'(j_reg);
    // position j is at its maximum when pos + k == count + j
    assign at_max    = (CW'(pos_cur) + CW'(k_reg)) == (CW'(count_reg) + CW'(j_reg));

    // next-state logic
    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        started_next   = started_reg;
        finished_next  = finished_reg;
        j_next         = j_reg;
        piv_found_next = piv_found_reg;
        piv_j_next     = piv_j_reg;
        piv_val_next   = piv_val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        item_we        = 1'b0;
        item_waddr     = count_reg[IDXW-1:0];
        item_re        = 1'b0;
        item_raddr     = pos_cur;
        pos_we         = 1'b0;
        pos_waddr      = IDXW'(j_reg);
        pos_wdata      = IDXW'(j_reg);
        pos_re         = 1'b0;
        pos_raddr      = IDXW'(j_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_tuser)
                        kce_pkg::OP_CLEAR:
                        begin
                            count_next    = '0;
                            started_next  = 1'b0;
                            finished_next = 1'b0;
                        end
                        kce_pkg::OP_APPEND:
                        begin
                            started_next  = 1'b0;
                            finished_next = 1'b0;
                            if (list_room)
                            begin
                                item_we    = 1'b1;
                                count_next = count_reg + CNTW'(1);
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_last_next  = 1'b0;
                                out_user_next  = '0;
                                out_user_next[kce_pkg::USER_FULL] = 1'b1;
                            end
                        end
                        kce_pkg::OP_NEXT:
                        begin
                            if (finished_reg || too_big)
                            begin
                                finished_next  = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_last_next  = 1'b0;
                                out_user_next  = '0;
                                out_user_next[kce_pkg::USER_EXH] = 1'b1;
                            end
                            else if (k_reg == '0)
                            begin
                                finished_next  = 1'b1;
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_last_next  = 1'b1;
                                out_user_next  = '0;
                                out_user_next[kce_pkg::USER_EMPTY] = 1'b1;
                            end
                            else
                            begin
                                j_next         = '0;
                                piv_found_next = 1'b0;
                                state_next     = ST_RPOS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (cfg_we)
                begin
                    k_next        = cfg_wdata;
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                end
            end

            // fetch position j
            ST_RPOS:
            begin
                pos_re     = 1'b1;
                state_next = ST_RITEM;
            end

            // fetch the item, seed the position, track the rightmost pivot
            ST_RITEM:
            begin
                item_re = 1'b1;
                if (!started_reg)
                begin
                    pos_we = 1'b1;
                end
                if (!at_max)
                begin
                    piv_found_next = 1'b1;
                    piv_j_next     = j_reg;
                    piv_val_next   = pos_cur + IDXW'(1);
                end
                state_next = ST_LOAD;
            end

            // move the item into the output register
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = item_rdata;
                    out_last_next  = j_last;
                    out_user_next  = '0;
                    if (j_last)
                    begin
                        started_next = 1'b1;
                        if (piv_found_reg)
                        begin
                            state_next = ST_ADV;
                        end
                        else
                        begin
                            finished_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + SW'(1);
                        state_next = ST_RPOS;
                    end
                end
            end

            // rewrite positions from the pivot to the end, ascending by one
            ST_ADV:
            begin
                pos_we       = 1'b1;
                pos_waddr    = IDXW'(piv_j_reg);
                pos_wdata    = piv_val_reg;
                piv_j_next   = piv_j_reg + SW'(1);
                piv_val_next = piv_val_reg + IDXW'(1);
                if (piv_j_reg == k_m1)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= SW'(1);
            count_reg     <= '0;
            started_reg   <= 1'b0;
            finished_reg  <= 1'b0;
            piv_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            started_reg   <= started_next;
            finished_reg  <= finished_next;
            piv_found_reg <= piv_found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        j_reg        <= j_next;
        piv_j_reg    <= piv_j_next;
        piv_val_reg  <= piv_val_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // item count stays within the list depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= CW'(MAX_ITEMS))
        else $error("item count beyond list depth");

    // position rewrite never runs past the subset size
    a_adv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADV) |-> (piv_j_reg < k_reg))
        else $error("position rewrite past subset size");

    // at most one status flag per result
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0(m_tuser))
        else $error("several status flags on one result");

    // an empty subset closes its run
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[kce_pkg::USER_EMPTY]) |-> m_tlast)
        else $error("empty subset without tlast");

    // once a run's last item is loaded the positions count as set up
    a_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && out_free && j_last) |=> started_reg)
        else $error("positions not marked set up after a run");

endmodule

FILE: tb/tb_k_combination_enumerator_top.sv
module tb_k_combination_enumerator_top;

    localparam logic [kce_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 450;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [kce_pkg::OP_W-1:0]   op;
        logic [kce_pkg::ITEM_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [kce_pkg::ITEM_W-1:0] item;
        logic                       last;
        logic                       empty;
        logic                       exh;
        logic                       full;
    } subset_beat_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [kce_pkg::ITEM_W-1:0]   s_tdata = '0;   // item_value
    logic [kce_pkg::OP_W-1:0]     s_tuser = '0;   // op
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [kce_pkg::ITEM_W-1:0]   m_tdata;        // subset_item
    logic                         m_tlast;        // last_of_subset
    logic [kce_pkg::USER_W-1:0]   m_tuser;        // empty_subset, exhausted, list_full
    logic                         cfg_we = 1'b0;
    logic [kce_pkg::SIZE_W-1:0]   cfg_wdata = '0; // k, items per subset

    k_combination_enumerator_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // pending input transactions and results still owed by the block
    request_t     request_q[$];
    subset_beat_t subset_beats_due[$];

    // shadow of the enumerator state
    logic [kce_pkg::ITEM_W-1:0] list_items[kce_pkg::MAX_ITEMS_DEF];
    int                         list_len = 0;
    int                         pos[kce_pkg::MAX_ITEMS_DEF];
    bit                         enum_started = 1'b0;
    bit                         enum_done = 1'b0;
    int                         k_size = 1;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int tx_gap_max = 3;
    int rx_mode = 1;
    int rx_tick = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    logic rx_ready_next;

    // bookkeeping
    request_t     cur_req;
    subset_beat_t want;
    int errors = 0;
    int cycles = 0;
    int queued_ops = 0;
    int requests_taken = 0;
    int beats_checked = 0;
    int exh_seen = 0;
    int empty_seen = 0;
    int full_seen = 0;
    int size_writes = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void add_beat(input logic [kce_pkg::ITEM_W-1:0] item, input logic last,
                                     input logic empty, input logic exh, input logic full);
        subset_beat_t b;
        b.item = item;
        b.last = last;
        b.empty = empty;
        b.exh = exh;
        b.full = full;
        subset_beats_due.insert(subset_beats_due.size(), b);
    endfunction

    // one accepted transaction applied to the shadow state
    function automatic void enumerate_step(input logic [kce_pkg::OP_W-1:0] op,
                                           input logic [kce_pkg::ITEM_W-1:0] value);
        int i;
        int j;
        case (op)
            kce_pkg::OP_CLEAR:
            begin
                list_len = 0;
                enum_started = 1'b0;
                enum_done = 1'b0;
            end
            kce_pkg::OP_APPEND:
            begin
                enum_started = 1'b0;
                enum_done = 1'b0;
                if (list_len < kce_pkg::MAX_ITEMS_DEF)
                begin
                    list_items[list_len] = value;
                    list_len++;
                end
                else
                    add_beat('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            kce_pkg::OP_NEXT:
            begin
                if (enum_done || k_size > list_len)
                begin
                    enum_done = 1'b1;
                    add_beat('0, 1'b0, 1'b0, 1'b1, 1'b0);
                end
                else if (k_size == 0)
                begin
                    enum_done = 1'b1;
                    add_beat('0, 1'b1, 1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    if (!enum_started)
                    begin
                        for (j = 0; j < k_size; j++)
                            pos[j] = j;
                        enum_started = 1'b1;
                    end
                    for (j = 0; j < k_size; j++)
                        add_beat(list_items[pos[j]], j == k_size - 1, 1'b0, 1'b0, 1'b0);
                    // step the rightmost position that can still move
                    i = k_size - 1;
                    while (i >= 0 && pos[i] == list_len - k_size + i)
                        i--;
                    if (i < 0)
                        enum_done = 1'b1;
                    else
                    begin
                        pos[i]++;
                        for (j = i + 1; j < k_size; j++)
                            pos[j] = pos[j-1] + 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // sender: bursts of transactions with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                enumerate_step(s_tuser, s_tdata);
                requests_taken++;
            end
            if (s_tvalid && !s_tready)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                cur_req = request_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_req.op;
                s_tdata <= cur_req.value;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: stall pattern per phase, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rx_ready_next = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: rx_ready_next = 1'b1;
                1: rx_ready_next = ($urandom_range(0, 2) != 0);
                2: rx_ready_next = ((rx_tick % 5) < 3);
                default: rx_ready_next = ($urandom_range(0, 7) == 0);
            endcase
        end
        rx_tick++;
        m_tready <= rx_ready_next;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (subset_beats_due.size() == 0)
            begin
                $error("unexpected result transaction: tdata %h tlast %b tuser %b",
                       m_tdata, m_tlast, m_tuser);
                errors++;
            end
            else
            begin
                want = subset_beats_due.pop_front();
                beats_checked++;
                if (want.exh)
                    exh_seen++;
                if (want.empty)
                    empty_seen++;
                if (want.full)
                    full_seen++;
                if (m_tdata !== want.item)
                begin
                    $error("subset_item: expected %h, got %h", want.item, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last_of_subset: expected %b, got %b", want.last, m_tlast);
                    errors++;
                end
                if (m_tuser[kce_pkg::USER_EMPTY] !== want.empty)
                begin
                    $error("empty_subset: expected %b, got %b", want.empty,
                           m_tuser[kce_pkg::USER_EMPTY]);
                    errors++;
                end
                if (m_tuser[kce_pkg::USER_EXH] !== want.exh)
                begin
                    $error("exhausted: expected %b, got %b", want.exh,
                           m_tuser[kce_pkg::USER_EXH]);
                    errors++;
                end
                if (m_tuser[kce_pkg::USER_FULL] !== want.full)
                begin
                    $error("list_full: expected %b, got %b", want.full,
                           m_tuser[kce_pkg::USER_FULL]);
                    errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic queue_op(input logic [kce_pkg::OP_W-1:0] op,
                            input logic [kce_pkg::ITEM_W-1:0] value);
        request_t r;
        r.op = op;
        r.value = value;
        request_q.insert(request_q.size(), r);
        if (op != OP_UNUSED)
            queued_ops++;
    endtask

    // sender idles until nothing is in flight
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (request_q.size() != 0 || s_tvalid || subset_beats_due.size() != 0);
    endtask

    task automatic write_k_size(input logic [kce_pkg::SIZE_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        k_size = value;
        enum_started = 1'b0;
        enum_done = 1'b0;
        size_writes++;
    endtask

    initial
    begin
        logic [kce_pkg::ITEM_W-1:0] corner_vals[4];
        int new_k;
        int list_n;
        int phase;

        corner_vals[0] = 32'h8000_0000;
        corner_vals[1] = 32'h7FFF_FFFF;
        corner_vals[2] = 32'hFFFF_FFFF;
        corner_vals[3] = 32'h0000_0000;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset size of one, empty list, extreme values, exhaustion
        queue_op(kce_pkg::OP_NEXT, '0);
        for (int c = 0; c < 4; c++)
            queue_op(kce_pkg::OP_APPEND, corner_vals[c]);
        repeat (5) queue_op(kce_pkg::OP_NEXT, '0);
        queue_op(OP_UNUSED, 32'hFFFF_FFFF);
        queue_op(kce_pkg::OP_NEXT, '0);
        queue_op(kce_pkg::OP_CLEAR, 32'hFFFF_FFFF);
        queue_op(kce_pkg::OP_NEXT, '0);

        // directed: empty subset once, then exhausted
        write_k_size(5'd0);
        queue_op(kce_pkg::OP_NEXT, '0);
        queue_op(kce_pkg::OP_NEXT, '0);

        // directed: one full subset of three
        write_k_size(5'd3);
        queue_op(kce_pkg::OP_APPEND, 32'h5555_5555);
        queue_op(kce_pkg::OP_APPEND, 32'hAAAA_AAAA);
        queue_op(kce_pkg::OP_APPEND, 32'h1234_5678);
        queue_op(kce_pkg::OP_NEXT, '0);
        queue_op(kce_pkg::OP_NEXT, '0);

        // random phases: list loads followed by runs of next requests
        phase = 0;
        while (queued_ops < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: new_k = 0;
                1: new_k = 16;
                2: new_k = $urandom_range(17, 31);
                3, 4: new_k = $urandom_range(7, 15);
                default: new_k = $urandom_range(1, 6);
            endcase
            write_k_size(new_k[kce_pkg::SIZE_W-1:0]);
            rx_mode = $urandom_range(0, 3);
            case ($urandom_range(0, 2))
                0: tx_gap_max = 0;
                1: tx_gap_max = 3;
                default: tx_gap_max = 12;
            endcase
            if (phase % 8 == 1)
                hold_req++;
            repeat ($urandom_range(1, 3))
            begin
                if (new_k > 8 || $urandom_range(0, 9) == 0)
                    list_n = $urandom_range(14, 19);
                else
                    list_n = $urandom_range(0, 8);
                queue_op(kce_pkg::OP_CLEAR, $urandom);
                repeat (list_n)
                    queue_op(kce_pkg::OP_APPEND, ($urandom_range(0, 7) == 0) ?
                             corner_vals[$urandom_range(0, 3)] : $urandom);
                repeat ($urandom_range(1, 12))
                begin
                    queue_op(kce_pkg::OP_NEXT, $urandom);
                    // occasional noise and sender pauses
                    case ($urandom_range(0, 15))
                        0: queue_op(OP_UNUSED, $urandom);
                        1: queue_op(kce_pkg::OP_APPEND, $urandom);
                        2: wait_drained();
                        default: ;
                    endcase
                end
            end
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d input transactions over %0d subset sizes, %0d results checked",
                 requests_taken, size_writes, beats_checked);
        $display("  of them %0d exhausted, %0d empty subsets, %0d dropped appends",
                 exh_seen, empty_seen, full_seen);
        if (errors == 0 && subset_beats_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
